### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define PPGBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define PPGBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ppgbd_pkg.sv
// Package with widths, constants and codes of the beat detector.
`timescale 1ns / 1ps
package ppgbd_pkg;

  localparam int unsigned WIN_LEN     = 10;
  localparam int unsigned SAMPLE_W    = 18;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LEVEL_W     = 22;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned IVAL_W      = 16;
  localparam int unsigned BPM_W       = 13;
  localparam int unsigned PROD_W      = 30;
  localparam int unsigned WPOS_W      = $clog2(WIN_LEN);

  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned RATE_NUM    = 600000;
  localparam int unsigned RATE_NUM_W  = 20;
  localparam int unsigned BPM_MAX     = 6000;
  localparam int unsigned DIV_CNT_W   = $clog2(RATE_NUM_W + 1);

  localparam int unsigned IN_DATA_W   = 56;
  localparam int unsigned OUT_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned OUT_BEAT_BIT    = 0;
  localparam int unsigned OUT_IVAL_LSB    = 1;
  localparam int unsigned OUT_BPM_LSB     = 17;
  localparam int unsigned OUT_CONTACT_BIT = 30;

  localparam logic [LEVEL_W-1:0] CONTACT_RST = LEVEL_W'(400);
  localparam logic [LEVEL_W-1:0] RELEASE_RST = LEVEL_W'(300);
  localparam logic [LEVEL_W-1:0] SPAN_RST    = LEVEL_W'(50);
  localparam logic [PCT_W-1:0]   PCT_RST     = PCT_W'(45);
  localparam logic [IVAL_W-1:0]  MIN_IV_RST  = IVAL_W'(429);
  localparam logic [IVAL_W-1:0]  MAX_IV_RST  = IVAL_W'(1500);

  typedef enum logic [2:0] {
    REG_CONTACT_LEVEL = 3'd0,
    REG_RELEASE_LEVEL = 3'd1,
    REG_MIN_SPAN      = 3'd2,
    REG_THRESH_PCT    = 3'd3,
    REG_MIN_INTERVAL  = 3'd4,
    REG_MAX_INTERVAL  = 3'd5
  } reg_idx_t;

endpackage

### sv/ppg_beat_detector_top.sv
// Top level of the infrared pulse beat detector.
// Usage:
//   in_*  : one transaction per sample; in_tdata carries ir_sample and time_ms.
//   out_* : one result transaction per sample; beat, interval_ms, bpm_tenths,
//           in_contact packed in out_tdata.
//   cfg_* : APB-style register port, written by the user only while the block is idle (unchecked).
// The ten-sample window lives in a synchronous memory; each sample reads the
// entry it overwrites and updates a running sum.
// A sample passes S_SUM, S_CTRL and S_DONE if contact changes or is absent,
// adds S_MUL and S_CMP when tracking, and S_DIV, the 20-step serial divider
// for the rate, on a valid beat. One sample is in work at a time, so
// in_tready returns high in the cycle the result appears on out_tvalid.
// A finished result waits in the output register while out_tready is low;
// the next sample may already be accepted and is held before loading.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// window valid bits, contact and beat history; no clearing pass is needed.
`timescale 1ns / 1ps
module ppg_beat_detector_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [17:0] ir_sample, [49:18] time_ms
  input  logic [ppgbd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] beat, [16:1] interval_ms, [29:17] bpm_tenths, [30] in_contact
  output logic [ppgbd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ppgbd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ppgbd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ppgbd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned LW = ppgbd_pkg::LEVEL_W;
  localparam int unsigned SW = ppgbd_pkg::SAMPLE_W;
  localparam int unsigned PW = ppgbd_pkg::PROD_W;
  localparam int unsigned IW = ppgbd_pkg::IVAL_W;
  localparam int unsigned TW = ppgbd_pkg::TIME_W;
  localparam int unsigned BW = ppgbd_pkg::BPM_W;
  localparam int unsigned QW = ppgbd_pkg::RATE_NUM_W;
  localparam int unsigned AW = ppgbd_pkg::WPOS_W;
  localparam int unsigned CW = ppgbd_pkg::DIV_CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_CTRL, S_MUL, S_CMP, S_DIV, S_DONE
  } state_t;

  // configuration
  logic [LW-1:0]                 contact_lvl_r, release_lvl_r, min_span_r;
  logic [ppgbd_pkg::PCT_W-1:0]   thr_pct_r;
  logic [IW-1:0]                 min_iv_r, max_iv_r;
  logic                          cfg_wr;
  ppgbd_pkg::reg_idx_t           cfg_idx;

  // window memory
  logic [SW-1:0]                 win_mem [ppgbd_pkg::WIN_LEN];
  logic [SW-1:0]                 rd_data_r;
  logic [ppgbd_pkg::WIN_LEN-1:0] win_vld_r;
  logic [AW-1:0]                 wpos_r;
  logic                          rd_en, wr_en;

  // control and tracking state
  state_t                        state_r;
  logic [LW-1:0]                 sum_r, prev_sum_r, peak_r, trough_r;
  logic                          rising_r, contact_r, beat_seen_r;
  logic [TW-1:0]                 last_time_r;
  logic [BW-1:0]                 held_bpm_r;
  logic                          beat_r;
  logic [IW-1:0]                 ival_r;
  logic [CW-1:0]                 div_cnt_r;
  logic [IW-1:0]                 div_rem_r;
  logic [QW-1:0]                 div_quo_r;
  logic                          out_tvalid_r;
  logic [ppgbd_pkg::OUT_DATA_W-1:0] out_tdata_r;

  // payload
  logic [SW-1:0]                 smp_r;
  logic [TW-1:0]                 time_r;
  logic [PW-1:0]                 lhs_r, trough100_r, prod_r;
  logic                          span_ok_r;

  // combinational
  logic                          in_acc;
  logic [SW-1:0]                 old_smp;
  logic [LW-1:0]                 sum_nxt;
  logic [LW-1:0]                 span;
  logic [PW-1:0]                 rhs;
  logic                          rise_set, rising_eff, fall;
  logic [TW-1:0]                 ival_full;
  logic                          ival_ok;
  logic [IW:0]                   div_trial;
  logic                          div_ge;
  logic [QW-1:0]                 bpm_full;
  logic                          out_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = ppgbd_pkg::reg_idx_t'(cfg_paddr[ppgbd_pkg::CFG_ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      ppgbd_pkg::REG_CONTACT_LEVEL: cfg_prdata = 32'(contact_lvl_r);
      ppgbd_pkg::REG_RELEASE_LEVEL: cfg_prdata = 32'(release_lvl_r);
      ppgbd_pkg::REG_MIN_SPAN:      cfg_prdata = 32'(min_span_r);
      ppgbd_pkg::REG_THRESH_PCT:    cfg_prdata = 32'(thr_pct_r);
      ppgbd_pkg::REG_MIN_INTERVAL:  cfg_prdata = 32'(min_iv_r);
      ppgbd_pkg::REG_MAX_INTERVAL:  cfg_prdata = 32'(max_iv_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_lvl_r <= ppgbd_pkg::CONTACT_RST;
      release_lvl_r <= ppgbd_pkg::RELEASE_RST;
      min_span_r    <= ppgbd_pkg::SPAN_RST;
      thr_pct_r     <= ppgbd_pkg::PCT_RST;
      min_iv_r      <= ppgbd_pkg::MIN_IV_RST;
      max_iv_r      <= ppgbd_pkg::MAX_IV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ppgbd_pkg::REG_CONTACT_LEVEL: contact_lvl_r <= cfg_pwdata[LW-1:0];
        ppgbd_pkg::REG_RELEASE_LEVEL: release_lvl_r <= cfg_pwdata[LW-1:0];
        ppgbd_pkg::REG_MIN_SPAN:      min_span_r    <= cfg_pwdata[LW-1:0];
        ppgbd_pkg::REG_THRESH_PCT:    thr_pct_r     <= cfg_pwdata[ppgbd_pkg::PCT_W-1:0];
        ppgbd_pkg::REG_MIN_INTERVAL:  min_iv_r      <= cfg_pwdata[IW-1:0];
        ppgbd_pkg::REG_MAX_INTERVAL:  max_iv_r      <= cfg_pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign rd_en     = in_acc;
  assign wr_en     = (state_r == S_SUM);

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= win_mem[wpos_r];
    if (wr_en) win_mem[wpos_r] <= smp_r;
  end

  assign old_smp = win_vld_r[wpos_r] ? rd_data_r : '0;
  assign sum_nxt = sum_r + LW'(smp_r) - LW'(old_smp);

  assign span       = peak_r - trough_r;
  assign rhs        = trough100_r + prod_r;
  assign rise_set   = (lhs_r > rhs) && (sum_r > prev_sum_r);
  assign rising_eff = rising_r | rise_set;
  assign fall       = rising_eff && (sum_r < prev_sum_r);
  assign ival_full  = time_r - last_time_r;
  assign ival_ok    = (ival_full != '0) && (ival_full[TW-1:IW] == '0) &&
                      (ival_full[IW-1:0] >= min_iv_r) && (ival_full[IW-1:0] <= max_iv_r);

  assign div_trial = {div_rem_r, div_quo_r[QW-1]};
  assign div_ge    = div_trial >= {1'b0, ival_r};
  assign bpm_full  = div_quo_r;
  assign out_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r  <= in_tdata[SW-1:0];
      time_r <= in_tdata[SW +: TW];
    end
    if (state_r == S_MUL) begin
      lhs_r       <= PW'(sum_r) * PW'(ppgbd_pkg::PCT_SCALE);
      trough100_r <= PW'(trough_r) * PW'(ppgbd_pkg::PCT_SCALE);
      prod_r      <= PW'(span) * PW'(thr_pct_r);
      span_ok_r   <= span >= min_span_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_vld_r    <= '0;
      wpos_r       <= '0;
      sum_r        <= '0;
      prev_sum_r   <= '0;
      peak_r       <= '0;
      trough_r     <= '1;
      rising_r     <= 1'b0;
      contact_r    <= 1'b0;
      beat_seen_r  <= 1'b0;
      last_time_r  <= '0;
      held_bpm_r   <= '0;
      beat_r       <= 1'b0;
      ival_r       <= '0;
      div_cnt_r    <= '0;
      div_rem_r    <= '0;
      div_quo_r    <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            beat_r  <= 1'b0;
            ival_r  <= '0;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          sum_r             <= sum_nxt;
          win_vld_r[wpos_r] <= 1'b1;
          wpos_r            <= (wpos_r == AW'(ppgbd_pkg::WIN_LEN - 1)) ? '0 : wpos_r + 1'b1;
          state_r           <= S_CTRL;
        end
        S_CTRL: begin
          priority if (!contact_r && (sum_r > contact_lvl_r)) begin
            win_vld_r   <= '0;
            wpos_r      <= '0;
            sum_r       <= '0;
            prev_sum_r  <= '0;
            rising_r    <= 1'b0;
            beat_seen_r <= 1'b0;
            last_time_r <= '0;
            held_bpm_r  <= '0;
            contact_r   <= 1'b1;
            peak_r      <= sum_r;
            trough_r    <= sum_r;
            state_r     <= S_DONE;
          end else if (contact_r && (sum_r < release_lvl_r)) begin
            win_vld_r   <= '0;
            wpos_r      <= '0;
            sum_r       <= '0;
            prev_sum_r  <= '0;
            rising_r    <= 1'b0;
            beat_seen_r <= 1'b0;
            last_time_r <= '0;
            held_bpm_r  <= '0;
            contact_r   <= 1'b0;
            peak_r      <= '0;
            trough_r    <= '1;
            state_r     <= S_DONE;
          end else if (contact_r) begin
            if (sum_r > peak_r)   peak_r   <= sum_r;
            if (sum_r < trough_r) trough_r <= sum_r;
            state_r <= S_MUL;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_MUL: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          state_r <= S_DONE;
          if (span_ok_r) begin
            prev_sum_r <= sum_r;
            if (fall) begin
              rising_r    <= 1'b0;
              beat_seen_r <= 1'b1;
              last_time_r <= time_r;
              if (beat_seen_r && ival_ok) begin
                beat_r    <= 1'b1;
                ival_r    <= ival_full[IW-1:0];
                div_rem_r <= '0;
                div_quo_r <= QW'(ppgbd_pkg::RATE_NUM);
                div_cnt_r <= '0;
                state_r   <= S_DIV;
              end
            end else begin
              rising_r <= rising_eff;
            end
          end
        end
        S_DIV: begin
          div_rem_r <= div_ge ? IW'(div_trial - {1'b0, ival_r}) : div_trial[IW-1:0];
          div_quo_r <= {div_quo_r[QW-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == CW'(QW - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (beat_r) begin
            held_bpm_r <= (bpm_full > QW'(ppgbd_pkg::BPM_MAX)) ?
                          BW'(ppgbd_pkg::BPM_MAX) : bpm_full[BW-1:0];
          end
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {1'b0, contact_r,
                             beat_r ? ((bpm_full > QW'(ppgbd_pkg::BPM_MAX)) ?
                                       BW'(ppgbd_pkg::BPM_MAX) : bpm_full[BW-1:0])
                                    : held_bpm_r,
                             ival_r, beat_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sv/ppgbd_checker.sv
// Port-level checker of the beat detector and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppgbd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ppgbd_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic beat_bit, contact_bit;
  logic [ppgbd_pkg::IVAL_W-1:0] ival_f;
  logic [ppgbd_pkg::BPM_W-1:0]  bpm_f;

  assign beat_bit    = out_tdata[ppgbd_pkg::OUT_BEAT_BIT];
  assign contact_bit = out_tdata[ppgbd_pkg::OUT_CONTACT_BIT];
  assign ival_f      = out_tdata[ppgbd_pkg::OUT_IVAL_LSB +: ppgbd_pkg::IVAL_W];
  assign bpm_f       = out_tdata[ppgbd_pkg::OUT_BPM_LSB +: ppgbd_pkg::BPM_W];

  `PPGBD_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_tvalid && in_tready, !in_tready, "sample accepted while busy")
  `PPGBD_ASSERT(a_beat_needs_contact, clk, rst_n, !(out_tvalid && beat_bit) || (contact_bit && ival_f != '0 && bpm_f != '0), "beat without contact, interval or rate")
  `PPGBD_ASSERT(a_no_beat_no_ival, clk, rst_n, !(out_tvalid && !beat_bit) || (ival_f == '0), "interval without beat")
  `PPGBD_ASSERT(a_rate_cap, clk, rst_n, !out_tvalid || (bpm_f <= ppgbd_pkg::BPM_W'(ppgbd_pkg::BPM_MAX)), "rate above cap")
  `PPGBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped while stalled")

endmodule

bind ppg_beat_detector_top ppgbd_checker u_ppgbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
